// File: rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// Serial line command decoder package
// Shared constants, keyword table, result codes and the line result type.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);

  localparam int NUM_KW      = 7;
  localparam int KW_MAX_LEN  = 10;
  localparam int KW_BAUD_SET = 5;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [3:0] {
    CODE_HELP       = 4'd0,
    CODE_LED_ON     = 4'd1,
    CODE_LED_OFF    = 4'd2,
    CODE_LED_TOGGLE = 4'd3,
    CODE_STATUS     = 4'd4,
    CODE_SET_BAUD   = 4'd5,
    CODE_QUERY_BAUD = 4'd6,
    CODE_OVERFLOW   = 4'd7,
    CODE_UNKNOWN    = 4'd8,
    CODE_BAD_ARGS   = 4'd9
  } result_code_t;

  // Keyword texts, right aligned: the first character sits in the highest used byte.
  localparam logic [8*KW_MAX_LEN-1:0] KW_STR [NUM_KW] = '{
    80'("HELP"), 80'("LED ON"), 80'("LED OFF"), 80'("LED TOGGLE"),
    80'("STATUS"), 80'("BAUD="), 80'("BAUD?")
  };
  localparam int KW_LEN [NUM_KW] = '{4, 6, 7, 10, 6, 5, 5};

  typedef struct packed {
    logic         have;
    result_code_t code;
    logic [31:0]  baud;
  } line_result_t;

  // Character of keyword k at position idx; idx must be below the keyword length.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] idx);
    logic [8*KW_MAX_LEN-1:0] str;
    int                      sh;
    str = KW_STR[k];
    sh  = 8 * (KW_LEN[k] - 1 - int'(idx));
    return 8'(str >> sh);
  endfunction

endpackage

// File: rtl/sld_if.sv
// ----------------------------------------------------------------------------
// Serial line command decoder channels
// Valid/ready interfaces for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface sld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_code;
  logic [31:0] baud_value;

  modport source (output valid, output result_code, output baud_value, input ready);
  modport sink   (input valid, input result_code, input baud_value, output ready);
endinterface

// File: rtl/sld_line_core.sv
// ----------------------------------------------------------------------------
// Line state and keyword matcher
// Holds the per-line state, matches keywords and builds the BAUD= argument
// one byte per step, and gives the line result when CR or LF arrives.
// ----------------------------------------------------------------------------
module sld_line_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output sld_pkg::line_result_t result
);

  logic [sld_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       overflow_r, overflow_nxt;
  logic [7:0]                 first_r, first_nxt;
  logic                       comment_r, comment_nxt;
  logic [sld_pkg::NUM_KW-1:0] alive_r, alive_nxt;
  logic [31:0]                accum_r, accum_nxt;
  logic                       digits_r, digits_nxt;
  logic                       argbad_r, argbad_nxt;

  logic        is_eol;
  logic        is_digit;
  logic [31:0] pos_ext;
  logic [35:0] accum_wide;
  logic [31:0] accum_sat;
  logic        found;

  assign is_eol   = (rx_byte == sld_pkg::CHAR_LF) || (rx_byte == sld_pkg::CHAR_CR);
  assign is_digit = (rx_byte >= sld_pkg::CHAR_ZERO) && (rx_byte <= sld_pkg::CHAR_NINE);
  assign pos_ext  = 32'(count_r);

  // accum * 10 + digit, saturating at the 32-bit maximum.
  assign accum_wide = (36'(accum_r) << 3) + (36'(accum_r) << 1)
                    + 36'(rx_byte - sld_pkg::CHAR_ZERO);
  assign accum_sat  = (|accum_wide[35:32]) ? 32'hFFFF_FFFF : accum_wide[31:0];

  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    first_nxt    = first_r;
    comment_nxt  = comment_r;
    alive_nxt    = alive_r;
    accum_nxt    = accum_r;
    digits_nxt   = digits_r;
    argbad_nxt   = argbad_r;
    result       = '0;
    found        = 1'b0;

    if (step) begin
      if (is_eol) begin
        if (overflow_r) begin
          result.have = 1'b1;
          result.code = sld_pkg::CODE_OVERFLOW;
        end else if (count_r != '0 && first_r != sld_pkg::CHAR_HASH && !comment_r) begin
          result.have = 1'b1;
          result.code = sld_pkg::CODE_UNKNOWN;
          for (int k = 0; k < sld_pkg::NUM_KW; k++) begin
            if (!found && alive_r[k]) begin
              if (k == sld_pkg::KW_BAUD_SET) begin
                if (pos_ext >= 32'(sld_pkg::KW_LEN[k])) begin
                  found = 1'b1;
                  if (!digits_r || argbad_r) begin
                    result.code = sld_pkg::CODE_BAD_ARGS;
                  end else begin
                    result.code = sld_pkg::CODE_SET_BAUD;
                    result.baud = accum_r;
                  end
                end
              end else if (pos_ext == 32'(sld_pkg::KW_LEN[k])) begin
                found       = 1'b1;
                result.code = sld_pkg::result_code_t'(4'(k));
              end
            end
          end
        end
        count_nxt    = '0;
        overflow_nxt = 1'b0;
        first_nxt    = '0;
        comment_nxt  = 1'b0;
        alive_nxt    = '1;
        accum_nxt    = '0;
        digits_nxt   = 1'b0;
        argbad_nxt   = 1'b0;
      end else if (pos_ext < 32'(sld_pkg::LINE_CAPACITY - 1)) begin
        if (count_r == '0) begin
          first_nxt = rx_byte;
        end
        if (pos_ext == 32'd1 && first_r == sld_pkg::CHAR_SLASH
            && rx_byte == sld_pkg::CHAR_SLASH) begin
          comment_nxt = 1'b1;
        end
        for (int k = 0; k < sld_pkg::NUM_KW; k++) begin
          if (alive_r[k]) begin
            if (pos_ext < 32'(sld_pkg::KW_LEN[k])) begin
              if (sld_pkg::kw_char(k, pos_ext[3:0]) != rx_byte) begin
                alive_nxt[k] = 1'b0;
              end
            end else if (k == sld_pkg::KW_BAUD_SET) begin
              digits_nxt = 1'b1;
              if (is_digit) begin
                accum_nxt = accum_sat;
              end else begin
                argbad_nxt = 1'b1;
              end
            end else begin
              alive_nxt[k] = 1'b0;
            end
          end
        end
        count_nxt = count_r + 1'b1;
      end else begin
        overflow_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
      first_r    <= '0;
      comment_r  <= 1'b0;
      alive_r    <= '1;
      accum_r    <= '0;
      digits_r   <= 1'b0;
      argbad_r   <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
      first_r    <= first_nxt;
      comment_r  <= comment_nxt;
      alive_r    <= alive_nxt;
      accum_r    <= accum_nxt;
      digits_r   <= digits_nxt;
      argbad_r   <= argbad_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(sld_pkg::LINE_CAPACITY - 1))
    else $error("line count beyond capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> 32'(count_r) == 32'(sld_pkg::LINE_CAPACITY - 1))
    else $error("overflow flagged on a line that is not full");

  a_args_need_baud: assert property (@(posedge clk) disable iff (!rst_n)
    (digits_r || argbad_r) |-> alive_r[sld_pkg::KW_BAUD_SET])
    else $error("argument state set without a BAUD= prefix");

endmodule

// File: rtl/serial_line_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// Serial line command decoder
// Decodes CR/LF terminated text command lines from a stream of serial bytes.
//
// in_ch carries one received byte per word; out_ch carries one result word
// (result_code, baud_value) for each line that gives a result. Comment lines
// that do not overflow, empty lines and line ends that follow overflow-free
// blank input give none. A byte is registered at the input, runs through the
// line matcher once the output is free and, if it ends a line, its result is
// registered at the output. One byte is accepted per cycle while the output
// is free or being taken. When the receiver holds off out_ch.ready, the byte
// in the input register waits and in_ch.ready drops once that register is
// occupied; nothing is lost. Reset (rst_n low, synchronous) empties both
// registers and clears the line state, so the first byte after reset starts
// a new line.
// ----------------------------------------------------------------------------
module serial_line_command_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  sld_byte_if.sink            in_ch,
  sld_result_if.source        out_ch
);

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r, in_byte_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_code_r, out_code_nxt;
  logic [31:0] out_baud_r, out_baud_nxt;

  logic                  out_free;
  logic                  advance;
  logic                  in_take;
  sld_pkg::line_result_t line_res;

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;

  sld_line_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .result  (line_res)
  );

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_byte_nxt   = in_byte_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_baud_nxt  = out_baud_r;

    if (in_take) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_ch.rx_byte;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    if (advance && line_res.have) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = line_res.code;
      out_baud_nxt  = line_res.baud;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_byte_r  <= in_byte_nxt;
    out_code_r <= out_code_nxt;
    out_baud_r <= out_baud_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_code = out_code_r;
  assign out_ch.baud_value  = out_baud_r;

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_code_r <= sld_pkg::CODE_BAD_ARGS)
    else $error("result code out of range");

  a_baud_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_r != sld_pkg::CODE_SET_BAUD) |-> out_baud_r == '0)
    else $error("baud value nonzero on a result other than set_baud");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("input word lost while the output was stalled");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line command decoder testbench
// Streams text lines into the decoder one byte per word and checks every
// result word against a cycle-free line decoder kept in the bench. It covers
// exact keywords, near misses, comment and empty lines, BAUD= arguments with
// saturation and bad digits, line overflow, and random line traffic under
// random sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    sld_pkg::result_code_t code;
    logic [31:0]           baud;
  } cmd_result_t;

  localparam int NUM_RANDOM_BYTES = 170;
  localparam int CALM_TAIL_BYTES  = 40;

  logic clk;
  logic rst_n;

  sld_byte_if   byte_ch ();
  sld_result_if result_ch ();

  serial_line_command_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (result_ch)
  );

  // Keyword table in match priority order, with the code each one yields.
  string                 kw_txt  [sld_pkg::NUM_KW] = '{"HELP", "LED ON", "LED OFF",
                                                       "LED TOGGLE", "STATUS", "BAUD=",
                                                       "BAUD?"};
  sld_pkg::result_code_t kw_code [sld_pkg::NUM_KW] = '{sld_pkg::CODE_HELP,
                                                       sld_pkg::CODE_LED_ON,
                                                       sld_pkg::CODE_LED_OFF,
                                                       sld_pkg::CODE_LED_TOGGLE,
                                                       sld_pkg::CODE_STATUS,
                                                       sld_pkg::CODE_SET_BAUD,
                                                       sld_pkg::CODE_QUERY_BAUD};

  // Line state of the bench decoder.
  int                         ln_count;
  bit                         ln_overflow;
  logic [7:0]                 ln_first;
  bit                         ln_comment;
  logic [sld_pkg::NUM_KW-1:0] ln_alive;
  logic [31:0]                ln_number;
  bit                         ln_digits;
  bit                         ln_arg_bad;

  cmd_result_t expected_cmds[$];
  cmd_result_t head_cmd;
  int          error_count;
  int          sent_bytes;
  bit          idle_on;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_line_state();
    ln_count    = 0;
    ln_overflow = 1'b0;
    ln_first    = 8'h00;
    ln_comment  = 1'b0;
    ln_alive    = '1;
    ln_number   = 32'd0;
    ln_digits   = 1'b0;
    ln_arg_bad  = 1'b0;
  endfunction

  // Advances the line state by one byte; returns 1 when a line end gives a result.
  function automatic bit decode_byte(input logic [7:0] c, output cmd_result_t res);
    bit          have;
    logic [63:0] grown;
    res.code = sld_pkg::CODE_UNKNOWN;
    res.baud = 32'd0;
    have     = 1'b0;
    if (c == sld_pkg::CHAR_LF || c == sld_pkg::CHAR_CR) begin
      if (ln_overflow) begin
        res.code = sld_pkg::CODE_OVERFLOW;
        have     = 1'b1;
      end else if (ln_count != 0 && ln_first != sld_pkg::CHAR_HASH && !ln_comment) begin
        have = 1'b1;
        for (int k = 0; k < sld_pkg::NUM_KW; k++) begin
          if (ln_alive[k]) begin
            if (k == sld_pkg::KW_BAUD_SET) begin
              if (ln_count >= kw_txt[k].len()) begin
                if (!ln_digits || ln_arg_bad) begin
                  res.code = sld_pkg::CODE_BAD_ARGS;
                end else begin
                  res.code = sld_pkg::CODE_SET_BAUD;
                  res.baud = ln_number;
                end
                break;
              end
            end else if (ln_count == kw_txt[k].len()) begin
              res.code = kw_code[k];
              break;
            end
          end
        end
      end
      clear_line_state();
    end else if (ln_count < sld_pkg::LINE_CAPACITY - 1) begin
      if (ln_count == 0) ln_first = c;
      if (ln_count == 1 && ln_first == sld_pkg::CHAR_SLASH && c == sld_pkg::CHAR_SLASH)
        ln_comment = 1'b1;
      for (int k = 0; k < sld_pkg::NUM_KW; k++) begin
        if (ln_alive[k]) begin
          if (ln_count < kw_txt[k].len()) begin
            if (kw_txt[k][ln_count] != c) ln_alive[k] = 1'b0;
          end else if (k == sld_pkg::KW_BAUD_SET) begin
            ln_digits = 1'b1;
            if (c >= sld_pkg::CHAR_ZERO && c <= sld_pkg::CHAR_NINE) begin
              grown     = 64'(ln_number) * 64'd10 + 64'(c - sld_pkg::CHAR_ZERO);
              ln_number = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            end else begin
              ln_arg_bad = 1'b1;
            end
          end else begin
            ln_alive[k] = 1'b0;
          end
        end
      end
      ln_count++;
    end else begin
      ln_overflow = 1'b1;
    end
    return have;
  endfunction

  // Any byte except a line terminator.
  function automatic logic [7:0] rand_char();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == sld_pkg::CHAR_LF || v == sld_pkg::CHAR_CR);
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    cmd_result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent_bytes++;
    if (decode_byte(b, res)) expected_cmds.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Ends a line with CR or LF, sometimes as a CR LF pair.
  task automatic send_term();
    if ($urandom_range(0, 1) == 0) begin
      send_byte(sld_pkg::CHAR_LF);
    end else begin
      send_byte(sld_pkg::CHAR_CR);
      if ($urandom_range(0, 3) == 0) send_byte(sld_pkg::CHAR_LF);
    end
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_byte(sld_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic wait_drained();
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic test_keywords();
    for (int k = 0; k < sld_pkg::NUM_KW; k++) begin
      send_text(kw_txt[k]);
      send_term();
    end
    send_text("HELPX");   send_term();
    send_text("LED");     send_term();
    send_text("help");    send_term();
    send_byte(8'h00);     send_term();
    send_byte(8'hFF);     send_term();
  endtask

  task automatic test_ignored_lines();
    send_byte(sld_pkg::CHAR_LF);
    send_byte(sld_pkg::CHAR_CR);
    send_byte(sld_pkg::CHAR_LF);
    send_text("#HELP");   send_term();
    send_text("//HELP");  send_term();
    send_text("/H");      send_term();
  endtask

  task automatic test_baud_argument();
    send_text("BAUD=0");            send_term();
    send_text("BAUD=4294967295");   send_term();
    send_text("BAUD=4294967296");   send_term();
    send_text("BAUD=99999999999");  send_term();
    send_text("BAUD=");             send_term();
    send_text("BAUD= 12");          send_term();
    send_text("BAUD=+5");           send_term();
    send_text("BAUD=12a");          send_term();
    // Hold the sender back until the decoder has delivered everything.
    byte_ch.valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_line_overflow();
    // The longest line that fits, then one character more.
    for (int i = 0; i < sld_pkg::LINE_CAPACITY - 1; i++) send_byte(8'h41);
    send_term();
    for (int i = 0; i < sld_pkg::LINE_CAPACITY; i++) send_byte(8'h41);
    send_term();
    send_byte(sld_pkg::CHAR_HASH);
    for (int i = 0; i < sld_pkg::LINE_CAPACITY + 4; i++) send_byte(rand_char());
    send_term();
    send_text("STATUS");
    send_term();
  endtask

  task automatic send_random_line();
    int         kind;
    int         k;
    int         n;
    int         spot;
    logic [7:0] ch;
    kind = $urandom_range(0, 99);
    k    = $urandom_range(0, sld_pkg::NUM_KW - 1);
    if (kind < 25) begin
      send_text(kw_txt[k]);
    end else if (kind < 45) begin
      send_text("BAUD=");
      send_digits($urandom_range(0, 3) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 8));
    end else if (kind < 55) begin
      send_text("BAUD=");
      if ($urandom_range(0, 3) != 0) begin
        n    = $urandom_range(1, 6);
        spot = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
          if (i == spot) begin
            do ch = rand_char();
            while (ch >= sld_pkg::CHAR_ZERO && ch <= sld_pkg::CHAR_NINE);
            send_byte(ch);
          end else begin
            send_digits(1);
          end
        end
      end
    end else if (kind < 70) begin
      // A keyword with one character changed, cut short or extended.
      n    = kw_txt[k].len();
      spot = $urandom_range(0, n - 1);
      case ($urandom_range(0, 2))
        0: begin
          for (int i = 0; i < n; i++) send_byte(i == spot ? rand_char() : kw_txt[k][i]);
        end
        1: begin
          for (int i = 0; i < spot; i++) send_byte(kw_txt[k][i]);
        end
        default: begin
          send_text(kw_txt[k]);
          send_byte(rand_char());
        end
      endcase
    end else if (kind < 78) begin
      case ($urandom_range(0, 2))
        0:       send_byte(sld_pkg::CHAR_HASH);
        1:       send_text("//");
        default: send_byte(sld_pkg::CHAR_SLASH);
      endcase
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_byte(rand_char());
    end else if (kind < 84) begin
      // Empty line.
    end else if (kind < 98) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(sld_pkg::LINE_CAPACITY - 4, sld_pkg::LINE_CAPACITY + 6);
      for (int i = 0; i < n; i++) send_byte(rand_char());
    end
    send_term();
  endtask

  task automatic test_random_traffic();
    int start;
    start = sent_bytes;
    while (sent_bytes - start < NUM_RANDOM_BYTES) begin
      if (sent_bytes - start >= NUM_RANDOM_BYTES - CALM_TAIL_BYTES) idle_on = 1'b0;
      send_random_line();
    end
  endtask

  // Receiver: random stall bursts while idling is enabled.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("result word with none expected: result_code %0d baud_value %0d",
               result_ch.result_code, result_ch.baud_value);
        error_count++;
      end else begin
        head_cmd = expected_cmds.pop_front();
        if (result_ch.result_code !== head_cmd.code) begin
          $error("result_code: expected %0d, actual %0d", head_cmd.code,
                 result_ch.result_code);
          error_count++;
        end
        if (result_ch.baud_value !== head_cmd.baud) begin
          $error("baud_value: expected %0d, actual %0d", head_cmd.baud,
                 result_ch.baud_value);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    sent_bytes  = 0;
    idle_on     = 1'b1;
    clear_line_state();
    rst_n           <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_keywords();
    test_ignored_lines();
    test_baud_argument();
    test_line_overflow();
    test_random_traffic();

    byte_ch.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
